### design/hse_pkg.sv
// Shared types for the heap sort engine.
// No dependencies.
package hse_pkg;

    localparam int KEY_W = 32;
    localparam int TAG_W = 16;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } elem_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAP_READ,
        S_HEAP_LOAD,
        S_SORT_READ,
        S_SORT_SWAP,
        S_EVAL,
        S_PLACE,
        S_EMIT
    } state_t;

endpackage

### design/hse_store.sv
// Element memory: one write port, two read ports, registered read data.
// Depends on hse_pkg (elem_t).
module hse_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic           clk,
    input  logic           we,
    input  logic [AW-1:0]  waddr,
    input  hse_pkg::elem_t wdata,
    input  logic [AW-1:0]  raddr_a,
    input  logic [AW-1:0]  raddr_b,
    output hse_pkg::elem_t rdata_a,
    output hse_pkg::elem_t rdata_b
);
    import hse_pkg::*;

    elem_t mem [DEPTH];
    elem_t rdata_a_reg;
    elem_t rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

### design/heap_sort_engine.sv
// Heap sort engine top level: collection, heapsort sequencer, emission.
// Depends on hse_pkg and hse_store.
//
// A transaction (start high while busy is low) stores one key/tag pair.
// The item marked last_item raises busy. The stored set of n items is then sorted in place
// by heapsort over a two-read, one-write memory. At each sift level both children are read
// together while the parent is written. Each sift also has a read step plus a load or a swap
// step, and a place step when it runs down to a leaf. The sorted items then appear on
// consecutive cycles, one per cycle, each marked by result_valid; end_of_run marks the last.
// The receiver cannot hold results off. busy drops in the cycle that shows the last result.
// Items beyond MAX_ITEMS are dropped. Every result of such a set has overflowed set.
module heap_sort_engine #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [hse_pkg::KEY_W-1:0]  key,
    input  logic [hse_pkg::TAG_W-1:0]         tag,
    input  logic                              last_item,
    output logic                              result_valid,
    output logic signed [hse_pkg::KEY_W-1:0]  sorted_key,
    output logic [hse_pkg::TAG_W-1:0]         sorted_tag,
    output logic                              end_of_run,
    output logic                              overflowed
);
    import hse_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int IW = AW + 2;

    state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          heap_reg, heap_next;
    logic [AW-1:0] top_reg, top_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] node_reg, node_next;
    logic [CW-1:0] limit_reg, limit_next;
    elem_t         held_reg, held_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_end_reg, out_end_next;
    logic          out_ovf_reg, out_ovf_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    elem_t         mem_wdata;
    logic [AW-1:0] mem_raddr_a;
    logic [AW-1:0] mem_raddr_b;
    elem_t         rd_a;
    elem_t         rd_b;

    logic          accept;
    logic          room;
    logic [CW-1:0] n_next;
    logic [CW-1:0] lim;
    logic [IW-1:0] lim_ext;
    logic [IW-1:0] l_node;
    logic [IW-1:0] r_node;
    logic [IW-1:0] l_top;
    logic          pick_r;
    elem_t         chosen;
    logic [AW-1:0] chosen_idx;
    logic [IW-1:0] l_chosen;
    logic          do_swap;
    logic          sift_done;
    logic          emit_last;
    logic [AW-1:0] rnode;
    logic [IW-1:0] l_rnode;
    logic [IW-1:0] r_rnode;

    hse_store #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign room   = (count_reg < CW'(MAX_ITEMS));
    assign n_next = room ? CW'(count_reg + CW'(1)) : count_reg;

    // heap build uses the whole set, sort phase the shrunk range
    assign lim     = heap_reg ? count_reg : limit_reg;
    assign lim_ext = {{(IW-CW){1'b0}}, lim};

    assign l_node = {1'b0, node_reg, 1'b1};
    assign r_node = IW'(l_node + IW'(1));
    assign l_top  = {1'b0, top_reg, 1'b1};

    assign pick_r     = (r_node < lim_ext) && (rd_a.key < rd_b.key);
    assign chosen     = pick_r ? rd_b : rd_a;
    assign chosen_idx = pick_r ? r_node[AW-1:0] : l_node[AW-1:0];
    assign l_chosen   = {1'b0, chosen_idx, 1'b1};
    assign do_swap    = (held_reg.key < chosen.key);

    assign sift_done = ((state_reg == S_EVAL) && !do_swap) || (state_reg == S_PLACE);
    assign emit_last = (idx_reg == AW'(count_reg - CW'(1)));

    assign rnode   = (state_reg == S_HEAP_LOAD) ? top_reg :
                     (state_reg == S_SORT_SWAP) ? AW'(0) : chosen_idx;
    assign l_rnode = {1'b0, rnode, 1'b1};
    assign r_rnode = IW'(l_rnode + IW'(1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && last_item)
                begin
                    state_next = (n_next >= CW'(2)) ? S_HEAP_READ : S_EMIT;
                end
            end
            S_HEAP_READ:
            begin
                state_next = S_HEAP_LOAD;
            end
            S_HEAP_LOAD:
            begin
                state_next = (l_top < lim_ext) ? S_EVAL : S_PLACE;
            end
            S_SORT_READ:
            begin
                state_next = S_SORT_SWAP;
            end
            S_SORT_SWAP:
            begin
                state_next = (idx_reg > AW'(1)) ? S_EVAL : S_PLACE;
            end
            S_EVAL, S_PLACE:
            begin
                if ((state_reg == S_EVAL) && do_swap)
                begin
                    state_next = (l_chosen < lim_ext) ? S_EVAL : S_PLACE;
                end
                else if (heap_reg)
                begin
                    state_next = (top_reg == AW'(0)) ? S_SORT_READ : S_HEAP_READ;
                end
                else
                begin
                    state_next = (idx_reg == AW'(1)) ? S_EMIT : S_SORT_READ;
                end
            end
            S_EMIT:
            begin
                if (emit_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        heap_next      = heap_reg;
        top_next       = top_reg;
        idx_next       = idx_reg;
        node_next      = node_reg;
        limit_next     = limit_reg;
        held_next      = held_reg;
        out_valid_next = 1'b0;
        out_end_next   = 1'b0;
        out_ovf_next   = out_ovf_reg;
        mem_we         = 1'b0;
        mem_waddr      = node_reg;
        mem_wdata      = held_reg;
        mem_raddr_a    = l_rnode[AW-1:0];
        mem_raddr_b    = r_rnode[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mem_we    = room;
                    mem_waddr = count_reg[AW-1:0];
                    mem_wdata = '{key: key, tag: tag};
                    count_next = n_next;
                    if (!room)
                    begin
                        ovf_next = 1'b1;
                    end
                    heap_next = 1'b1;
                    top_next  = AW'((n_next - CW'(2)) >> 1);
                    idx_next  = '0;
                end
            end
            S_HEAP_READ:
            begin
                mem_raddr_a = top_reg;
            end
            S_HEAP_LOAD:
            begin
                held_next = rd_a;
                node_next = top_reg;
            end
            S_SORT_READ:
            begin
                mem_raddr_a = '0;
                mem_raddr_b = idx_reg;
            end
            S_SORT_SWAP:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = rd_a;
                held_next  = rd_b;
                node_next  = '0;
                limit_next = CW'(idx_reg);
            end
            S_EVAL, S_PLACE:
            begin
                mem_we = 1'b1;
                if ((state_reg == S_EVAL) && do_swap)
                begin
                    mem_wdata = chosen;
                    node_next = chosen_idx;
                end
            end
            S_EMIT:
            begin
                mem_raddr_a    = idx_reg;
                out_valid_next = 1'b1;
                out_end_next   = emit_last;
                out_ovf_next   = ovf_reg;
                idx_next       = AW'(idx_reg + AW'(1));
                if (emit_last)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase

        if (sift_done)
        begin
            if (heap_reg)
            begin
                if (top_reg == AW'(0))
                begin
                    heap_next = 1'b0;
                    idx_next  = AW'(count_reg - CW'(1));
                end
                else
                begin
                    top_next = AW'(top_reg - AW'(1));
                end
            end
            else
            begin
                idx_next = (idx_reg == AW'(1)) ? AW'(0) : AW'(idx_reg - AW'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            heap_reg      <= 1'b0;
            top_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_end_reg   <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            heap_reg      <= heap_next;
            top_reg       <= top_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            out_end_reg   <= out_end_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        limit_reg <= limit_next;
        held_reg  <= held_next;
    end

    assign result_valid = out_valid_reg;
    assign sorted_key   = rd_a.key;
    assign sorted_tag   = rd_a.tag;
    assign end_of_run   = out_end_reg;
    assign overflowed   = out_ovf_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ITEMS))
        else $error("item count above capacity");

    a_eval_has_child: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVAL |-> l_node < lim_ext)
        else $error("sift step on a node without children");

    a_end_marks_result: assert property (@(posedge clk) disable iff (!rst_n)
        end_of_run |-> result_valid)
        else $error("end_of_run without a result");

    a_emit_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !end_of_run |=> result_valid)
        else $error("gap inside a sorted run");

    a_last_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_item |=> busy)
        else $error("last item did not start the sort");

    a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && state_reg == S_IDLE |-> end_of_run)
        else $error("result shown while idle that is not the last");

endmodule
